### rtl/core/emgmc_pkg.sv
// Shared types, register indexes and reset values of the EMG pair to motor command block.
// Used by the controller, the datapath, the divider and the top level; depends on nothing.
`default_nettype none

package emgmc_pkg;

   // Default field widths and fixed widths
   localparam int LEVEL_BITS_DEF = 12;
   localparam int CMD_BITS_DEF   = 12;
   localparam int GAIN_BITS      = 16;
   localparam int GAIN_FRAC_BITS = 8;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   // Register reset values
   localparam int MIN_LEVEL_RST     = 100;
   localparam int MAX_LEVEL_RST     = 1000;
   localparam int MAX_COMMAND_RST   = 255;
   localparam int GAIN_Q8_RST       = 256;
   localparam int ACCEL_STEP_RST    = 4095;
   localparam int DECEL_STEP_RST    = 0;
   localparam int SQUARE_ENABLE_RST = 1;
   localparam int SLEW_ENABLE_RST   = 1;

   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;

   // Register indexes
   localparam csr_index_type REG_MIN_LEVEL     = 3'd0;
   localparam csr_index_type REG_MAX_LEVEL     = 3'd1;
   localparam csr_index_type REG_MAX_COMMAND   = 3'd2;
   localparam csr_index_type REG_GAIN_Q8       = 3'd3;
   localparam csr_index_type REG_ACCEL_STEP    = 3'd4;
   localparam csr_index_type REG_DECEL_STEP    = 3'd5;
   localparam csr_index_type REG_SQUARE_ENABLE = 3'd6;
   localparam csr_index_type REG_SLEW_ENABLE   = 3'd7;

   // Datapath operations issued by the controller
   typedef enum logic [3:0] {
      OP_NONE,
      OP_CAPTURE,
      OP_PREP,
      OP_MUL_GAIN,
      OP_MUL_CMD,
      OP_CMD_ZERO,
      OP_LIN_SAT,
      OP_DIV_LIN,
      OP_LIN_TAKE,
      OP_CMD_LIN,
      OP_SQ_MUL,
      OP_DIV_SQ,
      OP_CMD_SQ,
      OP_SLEW,
      OP_OUT
   } dp_op_type;

   typedef struct packed {
      dp_op_type op;
   } dp_cmd_type;

   typedef struct packed {
      logic active;       // at least one channel at or above min_level
      logic empty_range;  // max_level <= min_level
      logic lin_ovf;      // remap quotient would not fit the quotient width
      logic square_on;
      logic cmd_zero;     // max_command is zero
      logic div_done;
   } dp_sts_type;

   typedef struct packed {
      logic start;
      logic long_mode;    // full remap quotient, else command-wide quotient
   } div_cmd_type;

endpackage

`default_nettype wire

### rtl/core/emgmc_div.sv
// Restoring divider, one quotient bit per cycle, shared by remap and square shaping.
// Depends on emgmc_pkg for the command type.
`default_nettype none

module emgmc_div #(
   parameter int NUM_BITS   = 40,
   parameter int DEN_BITS   = 12,
   parameter int QUO_BITS   = 20,
   parameter int SHORT_BITS = 12
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire emgmc_pkg::div_cmd_type     cmd,
   input  wire logic [NUM_BITS-1:0]        num,
   input  wire logic [DEN_BITS-1:0]        den,
   output logic                            done,
   output logic [QUO_BITS-1:0]             quo
);

   localparam int CNT_BITS = $clog2(QUO_BITS + 1);

   logic                busy_ff, done_ff;
   logic [CNT_BITS-1:0] cnt_ff;
   logic [NUM_BITS-1:0] rem_ff, dsh_ff;
   logic [QUO_BITS-1:0] quo_ff;

   logic [NUM_BITS-1:0] den_ext;
   logic [NUM_BITS:0]   diff;
   logic                fits;

   assign den_ext = NUM_BITS'(den);
   assign diff    = {1'b0, rem_ff} - {1'b0, dsh_ff};
   assign fits    = ~diff[NUM_BITS];

   // Control: run for the selected number of quotient bits, pulse done at the end
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (cmd.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= cmd.long_mode ? CNT_BITS'(QUO_BITS) : CNT_BITS'(SHORT_BITS);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CNT_BITS'(1);
            if (cnt_ff == CNT_BITS'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Datapath: trial subtract of the shifted divisor, shift in one quotient bit
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         rem_ff <= num;
         dsh_ff <= cmd.long_mode ? (den_ext << (QUO_BITS - 1)) : (den_ext << (SHORT_BITS - 1));
         quo_ff <= '0;
      end else if (busy_ff) begin
         if (fits) begin
            rem_ff <= diff[NUM_BITS-1:0];
         end
         dsh_ff <= dsh_ff >> 1;
         quo_ff <= {quo_ff[QUO_BITS-2:0], fits};
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;

endmodule

`default_nettype wire

### rtl/core/emgmc_dp.sv
// Datapath: level select, clamp, gain and command multiplies, divider, slew limit, result word.
// Depends on emgmc_pkg and instantiates emgmc_div.
`default_nettype none

module emgmc_dp #(
   parameter int LEVEL_BITS = emgmc_pkg::LEVEL_BITS_DEF,
   parameter int CMD_BITS   = emgmc_pkg::CMD_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire emgmc_pkg::dp_cmd_type               cmd,
   output emgmc_pkg::dp_sts_type                    sts,
   input  wire logic [LEVEL_BITS-1:0]               req_emg_open,
   input  wire logic [LEVEL_BITS-1:0]               req_emg_close,
   input  wire logic [LEVEL_BITS-1:0]               min_level,
   input  wire logic [LEVEL_BITS-1:0]               max_level,
   input  wire logic [CMD_BITS-1:0]                 max_command,
   input  wire logic [emgmc_pkg::GAIN_BITS-1:0]     gain_q8,
   input  wire logic [CMD_BITS-1:0]                 accel_step,
   input  wire logic [CMD_BITS-1:0]                 decel_step,
   input  wire logic                                square_enable,
   input  wire logic                                slew_enable,
   output logic [CMD_BITS-1:0]                      rsp_motor_command,
   output logic                                     rsp_close_dir,
   output logic                                     rsp_dir_reversed
);

   localparam int PROD_BITS = LEVEL_BITS + emgmc_pkg::GAIN_BITS;
   localparam int NUM_BITS  = PROD_BITS + CMD_BITS;
   localparam int DEN_BITS  = (LEVEL_BITS > CMD_BITS) ? LEVEL_BITS : CMD_BITS;
   localparam int QUO_BITS  = CMD_BITS + emgmc_pkg::GAIN_FRAC_BITS;

   // Item registers
   logic                  active_ff, dir_ff, empty_ff;
   logic [LEVEL_BITS-1:0] lvl_ff, d_ff, span_ff;
   logic [PROD_BITS-1:0]  prod1_ff;
   logic [NUM_BITS-1:0]   num_ff;
   logic [CMD_BITS-1:0]   lin_ff, cmd_ff;

   // Carried state and result word
   logic                  last_dir_ff;
   logic [CMD_BITS-1:0]   last_cmd_ff;
   logic [CMD_BITS-1:0]   rsp_cmd_ff;
   logic                  rsp_dir_ff, rsp_rev_ff;

   // Divider
   emgmc_pkg::div_cmd_type div_cmd;
   logic [DEN_BITS-1:0]    div_den;
   logic                   div_done;
   logic [QUO_BITS-1:0]    div_quo;

   // Combinational helpers
   logic                  both_low, close_wins;
   logic [LEVEL_BITS-1:0] lvl_hi, lvl_c;
   logic [NUM_BITS-1:0]   ovf_bound;
   logic [CMD_BITS-1:0]   q_hi, slew_lo, slew_hi, slewed;
   logic [CMD_BITS:0]     hi_sum;

   // Pick the stronger channel; close wins only when strictly greater
   assign both_low   = (req_emg_open < min_level) && (req_emg_close < min_level);
   assign close_wins = req_emg_close > req_emg_open;

   // Clamp the level to [min_level, max_level]
   assign lvl_hi = (lvl_ff > max_level) ? max_level : lvl_ff;
   assign lvl_c  = (lvl_hi < min_level) ? min_level : lvl_hi;

   // A quotient beyond the quotient width saturates without dividing
   assign ovf_bound = NUM_BITS'(span_ff) << QUO_BITS;
   assign q_hi      = div_quo[QUO_BITS-1:emgmc_pkg::GAIN_FRAC_BITS];

   // Slew window around the previous command; when crossed, the lower bound wins only below it
   assign slew_lo = (last_cmd_ff > decel_step) ? (last_cmd_ff - decel_step) : '0;
   assign hi_sum  = {1'b0, last_cmd_ff} + {1'b0, accel_step};
   assign slew_hi = (hi_sum > {1'b0, max_command}) ? max_command : hi_sum[CMD_BITS-1:0];
   always_comb begin
      if (cmd_ff < slew_lo) begin
         slewed = slew_lo;
      end else if (cmd_ff > slew_hi) begin
         slewed = slew_hi;
      end else begin
         slewed = cmd_ff;
      end
   end

   // Divider commands
   assign div_cmd.start     = (cmd.op == emgmc_pkg::OP_DIV_LIN) || (cmd.op == emgmc_pkg::OP_DIV_SQ);
   assign div_cmd.long_mode = (cmd.op == emgmc_pkg::OP_DIV_LIN);
   assign div_den = (cmd.op == emgmc_pkg::OP_DIV_LIN) ? DEN_BITS'(span_ff) : DEN_BITS'(max_command);

   emgmc_div #(
      .NUM_BITS   (NUM_BITS),
      .DEN_BITS   (DEN_BITS),
      .QUO_BITS   (QUO_BITS),
      .SHORT_BITS (CMD_BITS)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .num   (num_ff),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   // Item datapath registers, advanced one operation at a time
   always_ff @(posedge clock) begin
      case (cmd.op)
         emgmc_pkg::OP_CAPTURE: begin
            active_ff <= ~both_low;
            dir_ff    <= both_low ? last_dir_ff : close_wins;
            lvl_ff    <= close_wins ? req_emg_close : req_emg_open;
         end
         emgmc_pkg::OP_PREP: begin
            d_ff     <= lvl_c - min_level;
            span_ff  <= max_level - min_level;
            empty_ff <= max_level <= min_level;
         end
         emgmc_pkg::OP_MUL_GAIN: begin
            prod1_ff <= PROD_BITS'(d_ff) * PROD_BITS'(gain_q8);
         end
         emgmc_pkg::OP_MUL_CMD: begin
            num_ff <= NUM_BITS'(prod1_ff) * NUM_BITS'(max_command);
         end
         emgmc_pkg::OP_CMD_ZERO: begin
            cmd_ff <= '0;
         end
         emgmc_pkg::OP_LIN_SAT: begin
            lin_ff <= max_command;
         end
         emgmc_pkg::OP_LIN_TAKE: begin
            lin_ff <= (q_hi > max_command) ? max_command : q_hi;
         end
         emgmc_pkg::OP_CMD_LIN: begin
            cmd_ff <= lin_ff;
         end
         emgmc_pkg::OP_SQ_MUL: begin
            num_ff <= NUM_BITS'(lin_ff) * NUM_BITS'(lin_ff);
         end
         emgmc_pkg::OP_CMD_SQ: begin
            cmd_ff <= div_quo[CMD_BITS-1:0];
         end
         emgmc_pkg::OP_SLEW: begin
            if (slew_enable) begin
               cmd_ff <= slewed;
            end
         end
         emgmc_pkg::OP_OUT: begin
            rsp_cmd_ff <= cmd_ff;
            rsp_dir_ff <= dir_ff;
            rsp_rev_ff <= dir_ff != last_dir_ff;
         end
         default: begin
         end
      endcase
   end

   // Carried state: update when the result word is loaded
   always_ff @(posedge clock) begin
      if (reset) begin
         last_dir_ff <= 1'b1;
         last_cmd_ff <= '0;
      end else if (cmd.op == emgmc_pkg::OP_OUT) begin
         last_dir_ff <= dir_ff;
         last_cmd_ff <= cmd_ff;
      end
   end

   // Status to the controller
   assign sts.active      = active_ff;
   assign sts.empty_range = empty_ff;
   assign sts.lin_ovf     = num_ff >= ovf_bound;
   assign sts.square_on   = square_enable;
   assign sts.cmd_zero    = max_command == '0;
   assign sts.div_done    = div_done;

   assign rsp_motor_command = rsp_cmd_ff;
   assign rsp_close_dir     = rsp_dir_ff;
   assign rsp_dir_reversed  = rsp_rev_ff;

endmodule

`default_nettype wire

### rtl/core/emgmc_ctrl.sv
// Controller: sequences one word through the datapath and owns both handshakes.
// Depends on emgmc_pkg for the command and status types.
`default_nettype none

module emgmc_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output emgmc_pkg::dp_cmd_type       cmd,
   input  wire emgmc_pkg::dp_sts_type  sts
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PREP,
      ST_MUL_GAIN,
      ST_MUL_CMD,
      ST_CHECK,
      ST_DIV_LIN,
      ST_SHAPE,
      ST_SQ_START,
      ST_SQ_WAIT,
      ST_SLEW,
      ST_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // Next state, datapath operation and result valid
   always_comb begin
      state_in     = state_ff;
      cmd.op       = emgmc_pkg::OP_NONE;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op   = emgmc_pkg::OP_CAPTURE;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.op   = emgmc_pkg::OP_PREP;
            state_in = ST_MUL_GAIN;
         end
         ST_MUL_GAIN: begin
            cmd.op   = emgmc_pkg::OP_MUL_GAIN;
            state_in = ST_MUL_CMD;
         end
         ST_MUL_CMD: begin
            cmd.op   = emgmc_pkg::OP_MUL_CMD;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            // Both channels inactive: zero command, skip shaping
            if (!sts.active) begin
               cmd.op   = emgmc_pkg::OP_CMD_ZERO;
               state_in = ST_SLEW;
            end else if (sts.empty_range || sts.lin_ovf) begin
               cmd.op   = emgmc_pkg::OP_LIN_SAT;
               state_in = ST_SHAPE;
            end else begin
               cmd.op   = emgmc_pkg::OP_DIV_LIN;
               state_in = ST_DIV_LIN;
            end
         end
         ST_DIV_LIN: begin
            if (sts.div_done) begin
               cmd.op   = emgmc_pkg::OP_LIN_TAKE;
               state_in = ST_SHAPE;
            end
         end
         ST_SHAPE: begin
            if (!sts.square_on) begin
               cmd.op   = emgmc_pkg::OP_CMD_LIN;
               state_in = ST_SLEW;
            end else if (sts.cmd_zero) begin
               cmd.op   = emgmc_pkg::OP_CMD_ZERO;
               state_in = ST_SLEW;
            end else begin
               cmd.op   = emgmc_pkg::OP_SQ_MUL;
               state_in = ST_SQ_START;
            end
         end
         ST_SQ_START: begin
            cmd.op   = emgmc_pkg::OP_DIV_SQ;
            state_in = ST_SQ_WAIT;
         end
         ST_SQ_WAIT: begin
            if (sts.div_done) begin
               cmd.op   = emgmc_pkg::OP_CMD_SQ;
               state_in = ST_SLEW;
            end
         end
         ST_SLEW: begin
            cmd.op   = emgmc_pkg::OP_SLEW;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            // Load the result word once the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op       = emgmc_pkg::OP_OUT;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Hold state and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = state_ff == ST_IDLE;
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

### rtl/core/emg_pair_to_motor_command.sv
// Top level of the EMG pair to motor command block: configuration registers,
// controller and datapath. Depends on emgmc_pkg, emgmc_ctrl, emgmc_dp and emgmc_div.
`default_nettype none

// Takes one word of two averaged EMG levels at a time and returns one motor command word
// with direction and reversal flag. With the result side free, rsp_valid rises and the
// input opens again in the same cycle, as the final step loads the result word and returns
// to idle. The shared restoring divider produces CMD_BITS+8 quotient bits for the linear
// remap and CMD_BITS more for square shaping, one bit per cycle, beside the multiply, select
// and handoff steps. Words with both channels inactive, a saturated remap or shaping off
// skip one or both divider passes and finish sooner. A new word is accepted while the
// previous result still waits in the output register; the next result then holds in its
// final step until that one is taken. Configuration writes take effect at once and belong
// between words.

module emg_pair_to_motor_command #(
   parameter int LEVEL_BITS = emgmc_pkg::LEVEL_BITS_DEF,
   parameter int CMD_BITS   = emgmc_pkg::CMD_BITS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic [LEVEL_BITS-1:0]                req_emg_open,
   input  wire logic [LEVEL_BITS-1:0]                req_emg_close,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic [CMD_BITS-1:0]                       rsp_motor_command,
   output logic                                      rsp_close_dir,
   output logic                                      rsp_dir_reversed,
   input  wire logic                                 csr_wr_en,
   input  wire emgmc_pkg::csr_index_type             csr_index,
   input  wire logic [emgmc_pkg::CSR_DATA_BITS-1:0]  csr_wr_data
);

   logic [LEVEL_BITS-1:0]                min_level_ff, max_level_ff;
   logic [CMD_BITS-1:0]                  max_command_ff, accel_step_ff, decel_step_ff;
   logic [emgmc_pkg::GAIN_BITS-1:0]      gain_q8_ff;
   logic                                 square_enable_ff, slew_enable_ff;

   emgmc_pkg::dp_cmd_type dp_cmd;
   emgmc_pkg::dp_sts_type dp_sts;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         min_level_ff     <= LEVEL_BITS'(emgmc_pkg::MIN_LEVEL_RST);
         max_level_ff     <= LEVEL_BITS'(emgmc_pkg::MAX_LEVEL_RST);
         max_command_ff   <= CMD_BITS'(emgmc_pkg::MAX_COMMAND_RST);
         gain_q8_ff       <= emgmc_pkg::GAIN_BITS'(emgmc_pkg::GAIN_Q8_RST);
         accel_step_ff    <= CMD_BITS'(emgmc_pkg::ACCEL_STEP_RST);
         decel_step_ff    <= CMD_BITS'(emgmc_pkg::DECEL_STEP_RST);
         square_enable_ff <= 1'(emgmc_pkg::SQUARE_ENABLE_RST);
         slew_enable_ff   <= 1'(emgmc_pkg::SLEW_ENABLE_RST);
      end else if (csr_wr_en) begin
         case (csr_index)
            emgmc_pkg::REG_MIN_LEVEL:     min_level_ff     <= csr_wr_data[LEVEL_BITS-1:0];
            emgmc_pkg::REG_MAX_LEVEL:     max_level_ff     <= csr_wr_data[LEVEL_BITS-1:0];
            emgmc_pkg::REG_MAX_COMMAND:   max_command_ff   <= csr_wr_data[CMD_BITS-1:0];
            emgmc_pkg::REG_GAIN_Q8:       gain_q8_ff       <= csr_wr_data[emgmc_pkg::GAIN_BITS-1:0];
            emgmc_pkg::REG_ACCEL_STEP:    accel_step_ff    <= csr_wr_data[CMD_BITS-1:0];
            emgmc_pkg::REG_DECEL_STEP:    decel_step_ff    <= csr_wr_data[CMD_BITS-1:0];
            emgmc_pkg::REG_SQUARE_ENABLE: square_enable_ff <= csr_wr_data[0];
            emgmc_pkg::REG_SLEW_ENABLE:   slew_enable_ff   <= csr_wr_data[0];
            default: begin
            end
         endcase
      end
   end

   emgmc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (dp_cmd),
      .sts       (dp_sts)
   );

   emgmc_dp #(
      .LEVEL_BITS (LEVEL_BITS),
      .CMD_BITS   (CMD_BITS)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (dp_cmd),
      .sts               (dp_sts),
      .req_emg_open      (req_emg_open),
      .req_emg_close     (req_emg_close),
      .min_level         (min_level_ff),
      .max_level         (max_level_ff),
      .max_command       (max_command_ff),
      .gain_q8           (gain_q8_ff),
      .accel_step        (accel_step_ff),
      .decel_step        (decel_step_ff),
      .square_enable     (square_enable_ff),
      .slew_enable       (slew_enable_ff),
      .rsp_motor_command (rsp_motor_command),
      .rsp_close_dir     (rsp_close_dir),
      .rsp_dir_reversed  (rsp_dir_reversed)
   );

   // An accepted word keeps the input closed while it is being worked on
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input accepted a second word while one was in work");

   // A new result is loaded only from the final step, never straight from idle
   a_result_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared without a word in work");

   // Reset leaves no result pending
   a_reset_clears_result: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid survived reset");

endmodule

`default_nettype wire
